@@ sv/prtg_pkg.sv @@
// Package for the pre-trade risk gate: payload structs, codes, constants
// and the saturating add helper. No dependencies.
package prtg_pkg;

    localparam int NUM_SYMBOLS = 256;
    localparam int SYM_W = $clog2(NUM_SYMBOLS);

    typedef enum logic [2:0] {
        OP_CHECK   = 3'd0,
        OP_FILL    = 3'd1,
        OP_ADD_PNL = 3'd2,
        OP_DAILY   = 3'd3,
        OP_KILL    = 3'd4,
        OP_UNKILL  = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        VD_OK       = 3'd0,
        VD_KILL     = 3'd1,
        VD_SIZE     = 3'd2,
        VD_PRICE    = 3'd3,
        VD_FAT      = 3'd4,
        VD_POSITION = 3'd5,
        VD_GROSS    = 3'd6,
        VD_DLOSS    = 3'd7
    } t_verdict;

    typedef enum logic [2:0] {
        CFG_MAX_QTY   = 3'd0,
        CFG_MAX_POS   = 3'd1,
        CFG_GROSS_CAP = 3'd2,
        CFG_MAX_LOSS  = 3'd3,
        CFG_FAT_FRAC  = 3'd4,
        CFG_MIN_PRICE = 3'd5,
        CFG_MAX_PRICE = 3'd6
    } t_cfg_index;

    localparam logic [30:0] RST_MAX_QTY   = 31'd500;
    localparam logic [30:0] RST_MAX_POS   = 31'd5000;
    localparam logic [61:0] RST_GROSS_CAP = 62'd20000000000;
    localparam logic [39:0] RST_MAX_LOSS  = 40'd500000000;
    localparam logic [15:0] RST_FAT_FRAC  = 16'd1311;
    localparam logic [30:0] RST_MIN_PRICE = 31'd100;
    localparam logic [30:0] RST_MAX_PRICE = 31'd1000000000;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [7:0]         symbol_id;
        logic               side;
        logic signed [31:0] price;
        logic signed [31:0] quantity;
        logic [30:0]        bid_px;
        logic [30:0]        ask_px;
        logic signed [47:0] pnl_delta;
    } t_in_item;

    typedef struct packed {
        logic [2:0] verdict;
        logic       kill_active;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step1;
        logic step2;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_check;
    } t_sts;

    // Signed 64-bit add that saturates at the range limits.
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add64 = s[63:0];
        end
    endfunction

endpackage

@@ sv/pre_trade_risk_gate.sv @@
// Pre-trade risk gate, top level. A check's result is registered once its
// transaction, after acceptance, has gone through the read, multiply and commit
// steps around the single-port position memory; a new transaction is taken only
// after the last one commits, and later while a held result blocks a check.
// Reset (synchronous, active low) restores register defaults and clears the
// kill flag, accumulators and all position entries at once.
module pre_trade_risk_gate
    import prtg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    prtg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    prtg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (o_out)
    );

endmodule

@@ sv/prtg_ctrl.sv @@
// Controller state machine of the risk gate: sequences load, read,
// multiply and commit, and owns the result valid flag. Uses prtg_pkg.
module prtg_ctrl
    import prtg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_commit;

    // A check may only finish when the result register is free or draining.
    assign can_commit = !(i_sts.is_check && r_out_valid && i_out_stall);

    always_comb begin
        o_cmd.load   = i_in_valid && (r_state == S_IDLE);
        o_cmd.step1  = (r_state == S_READ);
        o_cmd.step2  = (r_state == S_MUL);
        o_cmd.commit = (r_state == S_COMMIT) && can_commit;
    end

    // Next state and next result valid.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_READ;
            S_READ:   n_state = S_MUL;
            S_MUL:    n_state = S_COMMIT;
            S_COMMIT: if (can_commit) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        n_out_valid = r_out_valid;
        if (o_cmd.commit && i_sts.is_check) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // A check never overwrites a result that is still held.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit && i_sts.is_check) |-> !(r_out_valid && i_out_stall))
        else $error("check committed over a held result");

    // An accepted transaction always moves on to the read step.
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_READ))
        else $error("accepted transaction did not start");

    // A result appears only after a check committed.
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.commit && i_sts.is_check))
        else $error("result valid without a committed check");

endmodule

@@ sv/prtg_dp.sv @@
// Datapath of the risk gate: configuration registers, position memory,
// accumulators, multipliers and the verdict logic. Uses prtg_pkg.
module prtg_dp
    import prtg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_in,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output t_out_item   o_out
);

    // Configuration registers.
    logic [30:0] r_max_qty, r_max_pos, r_min_price, r_max_price;
    logic [61:0] r_gross_cap;
    logic [39:0] r_max_loss;
    logic [15:0] r_fat_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_qty   <= RST_MAX_QTY;
            r_max_pos   <= RST_MAX_POS;
            r_gross_cap <= RST_GROSS_CAP;
            r_max_loss  <= RST_MAX_LOSS;
            r_fat_frac  <= RST_FAT_FRAC;
            r_min_price <= RST_MIN_PRICE;
            r_max_price <= RST_MAX_PRICE;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MAX_QTY:   r_max_qty   <= i_cfg_data[30:0];
                CFG_MAX_POS:   r_max_pos   <= i_cfg_data[30:0];
                CFG_GROSS_CAP: r_gross_cap <= i_cfg_data[61:0];
                CFG_MAX_LOSS:  r_max_loss  <= i_cfg_data[39:0];
                CFG_FAT_FRAC:  r_fat_frac  <= i_cfg_data[15:0];
                CFG_MIN_PRICE: r_min_price <= i_cfg_data[30:0];
                CFG_MAX_PRICE: r_max_price <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Transaction fields captured at acceptance.
    t_opcode            r_op;
    logic [SYM_W-1:0]   r_idx;
    logic               r_side;
    logic signed [31:0] r_price, r_qty;
    logic [30:0]        r_bid, r_ask;
    logic signed [47:0] r_pnl;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_opcode'(i_in.opcode);
            r_idx   <= i_in.symbol_id[SYM_W-1:0];
            r_side  <= i_in.side;
            r_price <= i_in.price;
            r_qty   <= i_in.quantity;
            r_bid   <= i_in.bid_px;
            r_ask   <= i_in.ask_px;
            r_pnl   <= i_in.pnl_delta;
        end
    end

    assign o_sts.is_check = (r_op == OP_CHECK);

    // Position memory with one valid bit per entry; invalid entries read zero.
    logic signed [31:0]     mem_pos [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] r_pos_valid;
    logic signed [31:0]     r_mem_q;
    logic                   r_ent_valid;
    logic signed [33:0]     r_newpos;
    logic signed [31:0]     pos_sat;
    logic                   do_fill, do_daily;

    assign do_fill  = i_cmd.commit && (r_op == OP_FILL);
    assign do_daily = i_cmd.commit && (r_op == OP_DAILY);

    // Clamp the exact new position to the signed 32-bit range.
    always_comb begin
        if (r_newpos > 34'sh0_7FFF_FFFF) begin
            pos_sat = 32'sh7FFF_FFFF;
        end else if (r_newpos < -34'sh0_8000_0000) begin
            pos_sat = 32'sh8000_0000;
        end else begin
            pos_sat = r_newpos[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_fill) begin
            mem_pos[r_idx] <= pos_sat;
        end
        if (i_cmd.step1) begin
            r_mem_q <= mem_pos[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || do_daily) begin
            r_pos_valid <= '0;
        end else if (do_fill) begin
            r_pos_valid[r_idx] <= 1'b1;
        end
    end

    // Step one: fat-finger threshold and reference price.
    logic [30:0]        best_sel, r_thr, mid;
    logic [46:0]        thr_prod;
    logic signed [31:0] r_refp;

    assign best_sel = r_side ? r_bid : r_ask;
    assign thr_prod = {16'd0, best_sel} * {31'd0, r_fat_frac};
    assign mid      = 31'(({1'b0, r_bid} + {1'b0, r_ask}) >> 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.step1) begin
            r_thr       <= thr_prod[46:16];
            r_ent_valid <= r_pos_valid[r_idx];
            if (r_op == OP_FILL || r_price > 32'sd0) begin
                r_refp <= r_price;
            end else begin
                r_refp <= {1'b0, mid};
            end
        end
    end

    // Step two: new position and notional.
    logic signed [33:0] pos_ext, qty_ext;
    logic signed [63:0] r_notional;

    assign pos_ext = r_ent_valid ? {{2{r_mem_q[31]}}, r_mem_q} : 34'sd0;
    assign qty_ext = {{2{r_qty[31]}}, r_qty};

    always_ff @(posedge i_clk) begin
        if (i_cmd.step2) begin
            r_newpos   <= r_side ? (pos_ext - qty_ext) : (pos_ext + qty_ext);
            r_notional <= 64'(r_qty * r_refp);
        end
    end

    // Commit step: verdict of a check, in test order.
    logic               r_kill;
    logic signed [63:0] r_daily, r_gross, gross_next, loss_lim;
    logic signed [33:0] price_ext, ask_lim, bid_lim, maxp_ext;
    t_verdict           verdict;

    assign gross_next = sat_add64(r_gross, r_notional);
    assign price_ext  = {{2{r_price[31]}}, r_price};
    assign ask_lim    = {3'd0, r_ask} + {3'd0, r_thr};
    assign bid_lim    = {3'd0, r_bid} - {3'd0, r_thr};
    assign maxp_ext   = {3'd0, r_max_pos};
    assign loss_lim   = 64'sd0 - {24'd0, r_max_loss};

    always_comb begin
        if (r_kill) begin
            verdict = VD_KILL;
        end else if (r_qty <= 32'sd0 || r_qty > {1'b0, r_max_qty}) begin
            verdict = VD_SIZE;
        end else if (r_price != 32'sd0 &&
                     (r_price < {1'b0, r_min_price} || r_price > {1'b0, r_max_price})) begin
            verdict = VD_PRICE;
        end else if (r_price != 32'sd0 && !r_side && r_ask != '0 && price_ext > ask_lim) begin
            verdict = VD_FAT;
        end else if (r_price != 32'sd0 && r_side && r_bid != '0 && price_ext < bid_lim) begin
            verdict = VD_FAT;
        end else if (r_newpos > maxp_ext || r_newpos < -maxp_ext) begin
            verdict = VD_POSITION;
        end else if (gross_next > $signed({2'd0, r_gross_cap})) begin
            verdict = VD_GROSS;
        end else if (r_daily < loss_lim) begin
            verdict = VD_DLOSS;
        end else begin
            verdict = VD_OK;
        end
    end

    // Accumulators and kill flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kill  <= 1'b0;
            r_daily <= '0;
            r_gross <= '0;
        end else if (i_cmd.commit) begin
            case (r_op)
                OP_CHECK:   if (verdict == VD_DLOSS) r_kill <= 1'b1;
                OP_FILL:    r_gross <= gross_next;
                OP_ADD_PNL: r_daily <= sat_add64(r_daily, {{16{r_pnl[47]}}, r_pnl});
                OP_DAILY: begin
                    r_kill  <= 1'b0;
                    r_daily <= '0;
                    r_gross <= '0;
                end
                OP_KILL:    r_kill <= 1'b1;
                OP_UNKILL:  r_kill <= 1'b0;
                default: ;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_op == OP_CHECK) begin
            o_out.verdict     <= verdict;
            o_out.kill_active <= r_kill || (verdict == VD_DLOSS);
        end
    end

    // A daily reset leaves every position entry reading zero.
    a_daily_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_daily |=> (r_pos_valid == '0))
        else $error("daily reset left position entries valid");

    // A kill transaction always leaves the kill flag set.
    a_kill_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op == OP_KILL) |=> r_kill)
        else $error("kill flag not set");

    // A passing check only happens with the kill flag clear.
    a_ok_no_kill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op == OP_CHECK && verdict == VD_OK) |-> !r_kill)
        else $error("check passed while killed");

endmodule

@@ test/tb.sv @@
// Testbench for the pre-trade risk gate: directed and random events with a
// scoreboard that predicts verdicts. Depends on prtg_pkg and pre_trade_risk_gate.
module tb;
    import prtg_pkg::*;

    // Predicts verdicts of the risk gate and checks them in order.
    class verdict_board;
        logic [30:0] max_qty, max_pos, min_px, max_px;
        logic [61:0] gross_cap;
        logic [39:0] max_loss;
        logic [15:0] fat_frac;
        bit kill;
        longint pnl_acc, gross_acc;
        int pos[NUM_SYMBOLS];
        t_out_item pending[$];
        int errors, checked;
        int verdict_seen[8];

        function void clear_book();
            kill = 0;
            pnl_acc = 0;
            gross_acc = 0;
            foreach (pos[k]) pos[k] = 0;
        endfunction

        function void reset_all();
            max_qty = RST_MAX_QTY;
            max_pos = RST_MAX_POS;
            gross_cap = RST_GROSS_CAP;
            max_loss = RST_MAX_LOSS;
            fat_frac = RST_FAT_FRAC;
            min_px = RST_MIN_PRICE;
            max_px = RST_MAX_PRICE;
            clear_book();
        endfunction

        function void write_reg(t_cfg_index idx, logic [63:0] v);
            case (idx)
                CFG_MAX_QTY:   max_qty = v[30:0];
                CFG_MAX_POS:   max_pos = v[30:0];
                CFG_GROSS_CAP: gross_cap = v[61:0];
                CFG_MAX_LOSS:  max_loss = v[39:0];
                CFG_FAT_FRAC:  fat_frac = v[15:0];
                CFG_MIN_PRICE: min_px = v[30:0];
                CFG_MAX_PRICE: max_px = v[30:0];
                default: ;
            endcase
        endfunction

        function longint sat_sum(longint a, longint b);
            logic signed [64:0] s;
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            return s[63:0];
        endfunction

        function t_verdict evaluate(t_in_item it);
            longint px, qty, bid, ask, thr, npos, refp, notional;
            px = it.price;
            qty = it.quantity;
            bid = {33'd0, it.bid_px};
            ask = {33'd0, it.ask_px};
            if (kill) return VD_KILL;
            if (qty <= 0 || qty > longint'(max_qty)) return VD_SIZE;
            if (px != 0) begin
                if (px < longint'(min_px) || px > longint'(max_px)) return VD_PRICE;
                if (it.side == 1'b0 && ask > 0) begin
                    thr = (ask * longint'(fat_frac)) >>> 16;
                    if (px > ask + thr) return VD_FAT;
                end else if (it.side == 1'b1 && bid > 0) begin
                    thr = (bid * longint'(fat_frac)) >>> 16;
                    if (px < bid - thr) return VD_FAT;
                end
            end
            npos = longint'(pos[it.symbol_id]) + (it.side ? -qty : qty);
            if (npos > longint'(max_pos) || npos < -longint'(max_pos)) return VD_POSITION;
            refp = (px > 0) ? px : (bid + ask) / 2;
            notional = qty * refp;
            if (sat_sum(gross_acc, notional) > longint'(gross_cap)) return VD_GROSS;
            if (pnl_acc < -longint'(max_loss)) begin
                kill = 1;
                return VD_DLOSS;
            end
            return VD_OK;
        endfunction

        // Notes one accepted input transaction and updates the book.
        function void note_event(t_in_item it);
            longint np, qty;
            t_out_item e;
            qty = it.quantity;
            case (it.opcode)
                OP_CHECK: begin
                    e.verdict = evaluate(it);
                    e.kill_active = kill;
                    pending.push_back(e);
                end
                OP_FILL: begin
                    np = longint'(pos[it.symbol_id]) + (it.side ? -qty : qty);
                    if (np > 64'sd2147483647) np = 64'sd2147483647;
                    if (np < -64'sd2147483648) np = -64'sd2147483648;
                    pos[it.symbol_id] = int'(np);
                    gross_acc = sat_sum(gross_acc, qty * longint'(it.price));
                end
                OP_ADD_PNL: pnl_acc = sat_sum(pnl_acc, longint'(it.pnl_delta));
                OP_DAILY:   clear_book();
                OP_KILL:    kill = 1;
                OP_UNKILL:  kill = 0;
                default: ;
            endcase
        endfunction

        // Checks one accepted result against the oldest expectation.
        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result verdict=%0d kill=%0d", $time,
                         got.verdict, got.kill_active);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            verdict_seen[e.verdict]++;
            if (got.verdict !== e.verdict) begin
                $display("%0t: verdict mismatch expected %0d actual %0d", $time,
                         e.verdict, got.verdict);
                errors++;
            end
            if (got.kill_active !== e.kill_active) begin
                $display("%0t: kill_active mismatch expected %0d actual %0d", $time,
                         e.kill_active, got.kill_active);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_stall, o_out_valid, i_out_stall;
    t_in_item i_in;
    t_out_item o_out;
    logic i_cfg_valid, o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [63:0] i_cfg_data;

    pre_trade_risk_gate dut (.*);

    verdict_board board;
    int send_idle_pct, stall_pct;
    bit hold_off;
    longint cycles;
    int sent;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog on total cycles.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 2000000) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver side: random stalls, long hold-off on request.
    initial begin
        i_out_stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) i_out_stall <= 1;
            else i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out);
    end

    // Valid drops at the falling edge after acceptance and stays low until the next item is offered.
    task automatic send_item(t_in_item it);
        @(negedge i_clk);
        while (($urandom_range(99) < send_idle_pct)) @(negedge i_clk);
        i_in <= it;
        i_in_valid <= 1;
        do @(posedge i_clk); while (o_in_stall);
        board.note_event(it);
        sent++;
        @(negedge i_clk);
        i_in_valid <= 0;
    endtask

    task automatic wait_idle();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_index idx, logic [63:0] v);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= v;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    function automatic t_in_item make_item(t_opcode op);
        t_in_item it;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.opcode = op;
        return it;
    endfunction

    // Mostly plausible orders near the market; sometimes raw noise.
    function automatic t_in_item rand_item();
        t_in_item it;
        int r, mid;
        r = $urandom_range(99);
        if (r < 55) it = make_item(OP_CHECK);
        else if (r < 75) it = make_item(OP_FILL);
        else if (r < 85) it = make_item(OP_ADD_PNL);
        else if (r < 89) it = make_item(OP_DAILY);
        else if (r < 93) it = make_item(OP_KILL);
        else if (r < 98) it = make_item(OP_UNKILL);
        else it = make_item(t_opcode'($urandom_range(7)));
        if ($urandom_range(9) < 8) begin
            mid = $urandom_range(100000, 50);
            it.symbol_id = 8'($urandom_range(7));
            it.bid_px = ($urandom_range(9) == 0) ? 31'd0 : 31'(mid - $urandom_range(20));
            it.ask_px = ($urandom_range(9) == 0) ? 31'd0 : 31'(mid + $urandom_range(20));
            it.price = ($urandom_range(5) == 0) ? 0 : mid + $urandom_range(600) - 300;
            it.quantity = $urandom_range(700) - 100;
            it.pnl_delta = $signed(48'(longint'($urandom_range(2000000)) - 1200000)) * 200;
        end
        return it;
    endfunction

    task automatic directed();
        t_in_item it;
        it = make_item(OP_CHECK);
        it.symbol_id = 8'd255; it.side = 1'b0; it.price = 1000;
        it.quantity = 10; it.bid_px = 31'd999; it.ask_px = 31'd1001;
        send_item(it);                                  // ordinary pass
        it.quantity = 0; send_item(it);                 // zero size
        it.quantity = 32'sh80000000; send_item(it);     // most negative size
        it.quantity = 501; send_item(it);               // over max size
        it.quantity = 10; it.price = 99; send_item(it); // below price range
        it.price = 32'sh7fffffff; send_item(it);        // above price range
        it.price = 32'sh80000000; send_item(it);        // negative price
        it.price = 1021; send_item(it);                 // buy at threshold
        it.price = 1020; send_item(it);                 // buy below threshold
        it.side = 1'b1; it.price = 980; send_item(it);  // sell at threshold
        it.bid_px = '0; send_item(it);                  // unknown bid skips test
        it.price = 0; it.bid_px = 31'h7fffffff; it.ask_px = 31'h7fffffff;
        send_item(it);                                  // market order, huge mid
        it = make_item(OP_FILL); it.symbol_id = 8'd3; it.side = 1'b0;
        it.quantity = 32'sh7fffffff; it.price = 32'sh7fffffff;
        send_item(it); send_item(it);                   // position saturates
        it = make_item(OP_CHECK); it.symbol_id = 8'd3; it.side = 1'b1;
        it.price = 500; it.quantity = 100; it.bid_px = '0; it.ask_px = '0;
        send_item(it);                                  // gross / position limits
        it = make_item(OP_ADD_PNL); it.pnl_delta = 48'sh800000000000;
        send_item(it); send_item(it);                   // daily pnl negative
        it = make_item(OP_DAILY); it.price = 32'sh7fffffff; send_item(it);
        it = make_item(OP_ADD_PNL); it.pnl_delta = -48'sd600000000; send_item(it);
        it = make_item(OP_CHECK); it.price = 0; it.quantity = 1;
        it.bid_px = 31'd100; it.ask_px = 31'd100; it.symbol_id = 8'd0;
        send_item(it);                                  // daily loss latches kill
        send_item(it);                                  // then refused by kill
        it.opcode = OP_UNKILL; send_item(it);
        it.opcode = t_opcode'(3'd6); send_item(it);     // unused opcodes
        it.opcode = t_opcode'(3'd7); send_item(it);
        it.opcode = OP_KILL; send_item(it);
        it.opcode = OP_DAILY; send_item(it);
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (n) send_item(rand_item());
        wait_idle();
    endtask

    task automatic config_set(int which);
        case (which)
            0: begin
                write_cfg(CFG_MAX_QTY, 64'h7fffffff);
                write_cfg(CFG_MAX_POS, 64'h7fffffff);
                write_cfg(CFG_GROSS_CAP, 64'h3fffffffffffffff);
                write_cfg(CFG_MAX_LOSS, 64'hffffffffff);
                write_cfg(CFG_FAT_FRAC, 64'hffff);
                write_cfg(CFG_MIN_PRICE, 64'd0);
                write_cfg(CFG_MAX_PRICE, 64'h7fffffff);
            end
            1: begin
                write_cfg(CFG_MAX_QTY, 64'd0);
                write_cfg(CFG_MAX_POS, 64'd0);
                write_cfg(CFG_GROSS_CAP, 64'd0);
                write_cfg(CFG_MAX_LOSS, 64'd0);
                write_cfg(CFG_FAT_FRAC, 64'd0);
                write_cfg(CFG_MIN_PRICE, 64'h7fffffff);
                write_cfg(CFG_MAX_PRICE, 64'd0);
            end
            default: begin
                write_cfg(CFG_MAX_QTY, 64'($urandom_range(600, 50)));
                write_cfg(CFG_MAX_POS, 64'($urandom_range(3000, 100)));
                write_cfg(CFG_GROSS_CAP, {$urandom_range(3), $urandom});
                write_cfg(CFG_MAX_LOSS, 64'($urandom_range(2000000000, 1000)));
                write_cfg(CFG_FAT_FRAC, 64'($urandom_range(4000)));
                write_cfg(CFG_MIN_PRICE, 64'($urandom_range(100)));
                write_cfg(CFG_MAX_PRICE, 64'($urandom_range(200000, 50000)));
            end
        endcase
    endtask

    initial begin
        board = new();
        board.reset_all();
        i_rst_n = 0; i_in_valid = 0; i_in = '0;
        i_cfg_valid = 0; i_cfg_index = CFG_MAX_QTY; i_cfg_data = '0;
        send_idle_pct = 0; stall_pct = 0; hold_off = 0; sent = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        directed();
        wait_idle();
        random_phase(300, 0, 0);
        random_phase(250, 78, 0);

        // Long receiver hold-off while the sender keeps offering.
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            repeat (30) send_item(rand_item());
        join
        wait_idle();

        config_set(0);
        random_phase(200, 0, 78);
        config_set(1);
        random_phase(100, 27, 27);
        config_set(2);
        random_phase(350, 27, 27);
        config_set(2);
        random_phase(490, 0, 0);
        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d events, checked %0d verdicts (ok %0d, kill %0d, loss %0d).",
                 sent, board.checked, board.verdict_seen[0], board.verdict_seen[1],
                 board.verdict_seen[7]);
        $display("Covered default, widest, tightest and random limits with idle/stall mixes.");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
sv/prtg_pkg.sv
sv/prtg_ctrl.sv
sv/prtg_dp.sv
sv/pre_trade_risk_gate.sv
test/tb.sv
